@@ design/cnl_pkg.sv @@
package cnl_pkg;

  // Input value width and the decimal digits it can reach
  localparam int IN_W  = 54;
  localparam int NDIG  = 17;
  localparam int BCD_W = 4 * NDIG;

  // Output field widths
  localparam int CNT_W = 5;

  typedef enum logic [1:0] {
    BRAND_NONE  = 2'd0,
    BRAND_LEN15 = 2'd1,
    BRAND_PFX4  = 2'd2,
    BRAND_PFX5  = 2'd3
  } brand_t;

  // Data handed from one conversion cell to the next
  typedef struct packed {
    logic [IN_W-1:0]  bin;
    logic [BCD_W-1:0] bcd;
  } dd_t;

  // One finished result
  typedef struct packed {
    logic              too_long;
    logic [CNT_W-1:0]  digit_count;
    brand_t            brand_code;
    logic              luhn_ok;
  } res_t;

endpackage

@@ design/card_number_luhn_and_prefix_class.sv @@
// Channel  Dir  Signals                    Beat contents
// s_*      in   s_tvalid s_tready s_tdata  card number
// m_*      out  m_tvalid m_tready m_tdata  Luhn result, brand, digit count, length flag
//
// One beat per cycle unless the output stalls; from acceptance to m_tvalid a beat
// passes 54 conversion cells (one per input bit, binary to BCD) and two classify
// stages, the first cell loading on the accepting edge.
// Reset clears the skid register and every valid bit; payload registers keep no reset.
// A waiting result (m_tvalid high, m_tready low) freezes the whole chain; one more beat
// is taken into the input skid.
module card_number_luhn_and_prefix_class #(
  parameter int MAX_DIGITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // [53:0] card_number, [55:54] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // [0] luhn_ok, [2:1] brand_code, [7:3] digit_count,
                                // [8] too_long, [15:9] zero
);
  import cnl_pkg::*;

  logic            en;
  logic            skid_valid;
  logic [IN_W-1:0] skid_data;
  logic            src_valid;
  dd_t             chain      [IN_W+1];
  logic            chain_vld  [IN_W+1];
  res_t            res;

  // Move the chain whenever the output register is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = !skid_valid;

  // Park one beat while the chain is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && s_tvalid && s_tready) begin
      skid_data <= s_tdata[IN_W-1:0];
    end
  end

  // Feed the first cell from the skid or straight from the input
  assign src_valid     = skid_valid || (s_tvalid && s_tready);
  assign chain_vld[0]  = src_valid;
  assign chain[0].bin  = skid_valid ? skid_data : s_tdata[IN_W-1:0];
  assign chain[0].bcd  = '0;

  // One shift-and-adjust cell per input bit
  for (genvar c = 0; c < IN_W; c++) begin : g_cell
    cnl_dd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_vld[c]),
      .in_data   (chain[c]),
      .out_valid (chain_vld[c+1]),
      .out_data  (chain[c+1])
    );
  end

  cnl_classify #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_classify (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_vld[IN_W]),
    .in_bcd    (chain[IN_W].bcd),
    .out_valid (m_tvalid),
    .out_res   (res)
  );

  assign m_tdata = {7'd0, res.too_long, res.digit_count, res.brand_code, res.luhn_ok};

`ifndef NO_ASSERTIONS
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !en) |=> (skid_valid && $stable(skid_data)))
    else $error("skid beat lost during stall");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:3] <= CNT_W'(MAX_DIGITS)))
    else $error("digit count above limit");

  a_long_nobrand: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> (m_tdata[2:1] == BRAND_NONE))
    else $error("brand on over-long number");

  a_len15: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:1] == BRAND_LEN15) |-> (m_tdata[7:3] == 5'd15))
    else $error("fifteen-digit brand with wrong length");
`endif

endmodule

@@ design/cnl_dd_cell.sv @@
module cnl_dd_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  cnl_pkg::dd_t  in_data,
  output logic          out_valid,
  output cnl_pkg::dd_t  out_data
);
  import cnl_pkg::*;

  logic [BCD_W-1:0] adj;
  dd_t              data_next;

  // Add three to every digit of five or more, then shift in the next binary bit
  always_comb begin
    adj = in_data.bcd;
    for (int d = 0; d < NDIG; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    data_next.bcd = {adj[BCD_W-2:0], in_data.bin[IN_W-1]};
    data_next.bin = {in_data.bin[IN_W-2:0], 1'b0};
  end

  // Track the beat held in this cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Hold the payload while the chain is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

@@ design/cnl_classify.sv @@
module cnl_classify #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [cnl_pkg::BCD_W-1:0] in_bcd,
  output logic                      out_valid,
  output cnl_pkg::res_t             out_res
);
  import cnl_pkg::*;

  localparam int NGRP  = 3;
  localparam int GRP_N = 6;

  // Luhn contribution of one digit; odd places are doubled and folded
  function automatic logic [3:0] luhn_val(input logic [3:0] d, input logic odd);
    logic [4:0] dbl;
    dbl = {d, 1'b0};
    if (!odd) begin
      return d;
    end else if (dbl >= 5'd10) begin
      return 4'(dbl - 5'd9);
    end else begin
      return 4'(dbl);
    end
  endfunction

  // True when the sum is a multiple of ten
  function automatic logic mult10(input logic [7:0] s);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (s == 8'(k * 10)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  logic [3:0]       dig [NDIG];
  logic [CNT_W-1:0] n_next;
  logic [3:0]       lead1_next;
  logic [3:0]       lead2_next;
  logic [5:0]       psum_next [NGRP];

  logic             s1_valid;
  logic [CNT_W-1:0] n;
  logic [3:0]       lead1;
  logic [3:0]       lead2;
  logic [5:0]       psum [NGRP];

  logic [7:0]       total;
  logic             longer;
  res_t             res_next;

  // Count digits, pick the two leading digits, sum Luhn values in groups
  always_comb begin
    n_next     = '0;
    lead1_next = '0;
    lead2_next = '0;
    for (int i = 0; i < NDIG; i++) begin
      dig[i] = in_bcd[4*i +: 4];
      if (dig[i] != 4'd0) begin
        n_next = CNT_W'(i + 1);
      end
    end
    for (int i = 0; i < NDIG; i++) begin
      if (n_next == CNT_W'(i + 1)) begin
        lead1_next = dig[i];
      end
      if (n_next == CNT_W'(i + 2)) begin
        lead2_next = dig[i];
      end
    end
    for (int g = 0; g < NGRP; g++) begin
      psum_next[g] = '0;
      for (int j = 0; j < GRP_N; j++) begin
        if (g * GRP_N + j < NDIG) begin
          psum_next[g] = psum_next[g]
                       + 6'(luhn_val(dig[g * GRP_N + j], ((g * GRP_N + j) % 2) == 1));
        end
      end
    end
  end

  // Finish the sum and classify by length and prefix
  always_comb begin
    total  = 8'(psum[0]) + 8'(psum[1]) + 8'(psum[2]);
    longer = n > CNT_W'(MAX_DIGITS);
    res_next.luhn_ok     = mult10(total);
    res_next.too_long    = longer;
    res_next.digit_count = longer ? CNT_W'(MAX_DIGITS) : n;
    res_next.brand_code  = BRAND_NONE;
    priority if (longer) begin
      res_next.brand_code = BRAND_NONE;
    end else if (n == 5'd15 && lead1 == 4'd3 && (lead2 == 4'd4 || lead2 == 4'd7)) begin
      res_next.brand_code = BRAND_LEN15;
    end else if ((n == 5'd13 || n == 5'd16) && lead1 == 4'd4) begin
      res_next.brand_code = BRAND_PFX4;
    end else if (n == 5'd16 && lead1 == 5'd5 && lead2 >= 4'd1 && lead2 <= 4'd5) begin
      res_next.brand_code = BRAND_PFX5;
    end else begin
      res_next.brand_code = BRAND_NONE;
    end
  end

  // Advance valids of both stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  // Hold payload of both stages while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      n       <= n_next;
      lead1   <= lead1_next;
      lead2   <= lead2_next;
      psum    <= psum_next;
      out_res <= res_next;
    end
  end

endmodule
